>>> rtl/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

    // Coefficient and root format.
    localparam int COEF_W = 16;
    localparam int FRAC_BITS = 8;

    // b*b and |a*c| each fit in 2*COEF_W bits. The discriminant needs two more bits.
    localparam int PROD_W = 2 * COEF_W;
    localparam int DISC_W = PROD_W + 2;
    localparam int ROOT_W = DISC_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // |-b +/- s| < 2^(ROOT_W+1), scaled by 2^FRAC_BITS.
    localparam int NUM_W = ROOT_W + 1 + FRAC_BITS;
    localparam int DEN_W = COEF_W + 1;

    typedef enum logic [1:0] {
        ST_REAL     = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_A_ZERO   = 2'd2
    } t_status;

    // One stage of the square root chain.
    typedef struct packed {
        logic                      valid;
        t_status                   status;
        logic [DISC_W-1:0]         rad;
        logic [REM_W-1:0]          rem;
        logic [ROOT_W-1:0]         root;
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
    } t_sq;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;
        logic             neg;
    } t_dv_lane;

    // One stage of the divider chain, both roots side by side.
    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [DEN_W-1:0] den;
        t_dv_lane         lp;
        t_dv_lane         lm;
    } t_dv;

endpackage
`default_nettype wire

>>> rtl/quadratic_root_solver_core.sv
`default_nettype none
// Throughput: one item per cycle while the output is not stalled; every stage of the square root and divider chains
// holds its own item.
// A stall at the output holds the whole pipeline and lowers o_in_ready.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
module quadratic_root_solver_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire signed [qrs_pkg::COEF_W-1:0]    i_coef_a,
    input  wire signed [qrs_pkg::COEF_W-1:0]    i_coef_b,
    input  wire signed [qrs_pkg::COEF_W-1:0]    i_coef_c,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic signed [qrs_pkg::COEF_W-1:0]   o_root_plus,
    output logic signed [qrs_pkg::COEF_W-1:0]   o_root_minus,
    output logic [1:0]                          o_status,
    output logic                                o_saturated
);

    localparam int CW = qrs_pkg::COEF_W;

    logic en;
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: magnitudes and the two products.
    logic                        r_s1_valid;
    logic [qrs_pkg::PROD_W-1:0]  r_b2;
    logic [qrs_pkg::PROD_W-1:0]  r_p;
    logic                        r_diff;
    logic signed [CW-1:0]        r_a1;
    logic signed [CW-1:0]        r_b1;
    logic [CW-1:0]               ma, mb, mc;

    always_comb begin
        ma = i_coef_a[CW-1] ? CW'(-i_coef_a) : i_coef_a;
        mb = i_coef_b[CW-1] ? CW'(-i_coef_b) : i_coef_b;
        mc = i_coef_c[CW-1] ? CW'(-i_coef_c) : i_coef_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
            r_b2       <= mb * mb;
            r_p        <= ma * mc;
            r_diff     <= i_coef_a[CW-1] ^ i_coef_c[CW-1];
            r_a1       <= i_coef_a;
            r_b1       <= i_coef_b;
        end
    end

    // Stage 2: discriminant and status, entering the square root chain.
    qrs_pkg::t_sq r_sq0;
    qrs_pkg::t_sq n_sq0;
    logic [qrs_pkg::DISC_W-1:0] b2x, p4;

    always_comb begin
        b2x = qrs_pkg::DISC_W'(r_b2);
        p4  = {r_p, 2'b00};
        n_sq0.valid = r_s1_valid;
        n_sq0.rem   = '0;
        n_sq0.root  = '0;
        n_sq0.a     = r_a1;
        n_sq0.b     = r_b1;
        n_sq0.rad   = r_diff ? b2x + p4 : b2x - p4;
        if (r_a1 == '0) begin
            n_sq0.status = qrs_pkg::ST_A_ZERO;
        end else if (!r_diff && p4 > b2x) begin
            n_sq0.status = qrs_pkg::ST_NEG_DISC;
        end else begin
            n_sq0.status = qrs_pkg::ST_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq0.valid <= 1'b0;
        end else if (en) begin
            r_sq0 <= n_sq0;
        end
    end

    qrs_pkg::t_sq sq [0:qrs_pkg::ROOT_W];
    assign sq[0] = r_sq0;

    genvar gi;
    generate
        for (gi = 0; gi < qrs_pkg::ROOT_W; gi++) begin : g_sqrt
            qrs_sqrt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_d     (sq[gi]),
                .o_q     (sq[gi+1])
            );
        end
    endgenerate

    // Numerators and denominator as magnitudes with the quotient sign.
    qrs_pkg::t_sq last_sq;
    qrs_pkg::t_dv r_dv0;
    qrs_pkg::t_dv n_dv0;
    logic signed [qrs_pkg::ROOT_W+1:0] np, nm;
    logic [qrs_pkg::ROOT_W:0]          mnp, mnm;

    always_comb begin
        last_sq = sq[qrs_pkg::ROOT_W];
        np  = $signed({2'b00, last_sq.root}) - (qrs_pkg::ROOT_W+2)'(last_sq.b);
        nm  = -(qrs_pkg::ROOT_W+2)'(last_sq.b) - $signed({2'b00, last_sq.root});
        mnp = np[qrs_pkg::ROOT_W+1] ? (qrs_pkg::ROOT_W+1)'(-np) : np[qrs_pkg::ROOT_W:0];
        mnm = nm[qrs_pkg::ROOT_W+1] ? (qrs_pkg::ROOT_W+1)'(-nm) : nm[qrs_pkg::ROOT_W:0];
        n_dv0.valid  = last_sq.valid;
        n_dv0.status = last_sq.status;
        n_dv0.den    = {(last_sq.a[CW-1] ? CW'(-last_sq.a) : last_sq.a), 1'b0};
        n_dv0.lp.rem = '0;
        n_dv0.lp.nq  = {mnp, {qrs_pkg::FRAC_BITS{1'b0}}};
        n_dv0.lp.neg = np[qrs_pkg::ROOT_W+1] ^ last_sq.a[CW-1];
        n_dv0.lm.rem = '0;
        n_dv0.lm.nq  = {mnm, {qrs_pkg::FRAC_BITS{1'b0}}};
        n_dv0.lm.neg = nm[qrs_pkg::ROOT_W+1] ^ last_sq.a[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0.valid <= 1'b0;
        end else if (en) begin
            r_dv0 <= n_dv0;
        end
    end

    qrs_pkg::t_dv dv [0:qrs_pkg::NUM_W];
    assign dv[0] = r_dv0;

    generate
        for (gi = 0; gi < qrs_pkg::NUM_W; gi++) begin : g_div
            qrs_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_d     (dv[gi]),
                .o_q     (dv[gi+1])
            );
        end
    endgenerate

    // Sign, clamp and the error cases.
    function automatic logic [CW:0] finish(input qrs_pkg::t_dv_lane l);
        logic [CW-1:0] v;
        logic          s;
        s = 1'b0;
        if (!l.neg) begin
            if (l.nq[qrs_pkg::NUM_W-1:CW-1] != '0) begin
                s = 1'b1;
                v = {1'b0, {(CW-1){1'b1}}};
            end else begin
                v = l.nq[CW-1:0];
            end
        end else begin
            if (l.nq > qrs_pkg::NUM_W'({1'b1, {(CW-1){1'b0}}})) begin
                s = 1'b1;
                v = {1'b1, {(CW-1){1'b0}}};
            end else begin
                v = CW'(-l.nq[CW-1:0]);
            end
        end
        return {s, v};
    endfunction

    qrs_pkg::t_dv last_dv;
    logic [CW:0]  fp, fm;

    always_comb begin
        last_dv = dv[qrs_pkg::NUM_W];
        fp = finish(last_dv.lp);
        fm = finish(last_dv.lm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= last_dv.valid;
            o_status    <= last_dv.status;
            if (last_dv.status == qrs_pkg::ST_REAL) begin
                o_root_plus  <= fp[CW-1:0];
                o_root_minus <= fm[CW-1:0];
                o_saturated  <= fp[CW] | fm[CW];
            end else begin
                o_root_plus  <= '0;
                o_root_minus <= '0;
                o_saturated  <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != qrs_pkg::ST_REAL |->
            o_root_plus == '0 && o_root_minus == '0 && !o_saturated)
        else $error("error status with non-zero result");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_root_plus == 16'sh7fff || o_root_plus == -16'sh8000 ||
            o_root_minus == 16'sh7fff || o_root_minus == -16'sh8000)
        else $error("saturated flag without a clamped root");

    a_hold_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(last_dv.valid) && $stable(last_sq.valid))
        else $error("pipeline moved during a stall");

    a_zero_a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq0.valid && r_sq0.a == '0 |-> r_sq0.status == qrs_pkg::ST_A_ZERO)
        else $error("zero leading coefficient not flagged");
`endif

endmodule
`default_nettype wire

>>> rtl/qrs_sqrt_cell.sv
`default_nettype none
module qrs_sqrt_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  qrs_pkg::t_sq    i_d,
    output qrs_pkg::t_sq    o_q
);

    qrs_pkg::t_sq r_q;
    qrs_pkg::t_sq n_q;

    logic [qrs_pkg::REM_W+1:0] remx;
    logic [qrs_pkg::REM_W+1:0] trial;

    always_comb begin
        n_q   = i_d;
        remx  = {i_d.rem, i_d.rad[qrs_pkg::DISC_W-1 -: 2]};
        trial = {2'b00, i_d.root, 2'b01};
        n_q.rad = {i_d.rad[qrs_pkg::DISC_W-3:0], 2'b00};
        if (remx >= trial) begin
            n_q.rem  = qrs_pkg::REM_W'(remx - trial);
            n_q.root = {i_d.root[qrs_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_q.rem  = qrs_pkg::REM_W'(remx);
            n_q.root = {i_d.root[qrs_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

>>> rtl/qrs_div_cell.sv
`default_nettype none
module qrs_div_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  qrs_pkg::t_dv    i_d,
    output qrs_pkg::t_dv    o_q
);

    qrs_pkg::t_dv r_q;
    qrs_pkg::t_dv n_q;

    function automatic qrs_pkg::t_dv_lane step(input qrs_pkg::t_dv_lane l,
                                               input logic [qrs_pkg::DEN_W-1:0] d);
        qrs_pkg::t_dv_lane     r;
        logic [qrs_pkg::DEN_W:0] remx;
        r    = l;
        remx = {l.rem, l.nq[qrs_pkg::NUM_W-1]};
        r.nq = {l.nq[qrs_pkg::NUM_W-2:0], 1'b0};
        if (remx >= {1'b0, d}) begin
            r.rem   = qrs_pkg::DEN_W'(remx - {1'b0, d});
            r.nq[0] = 1'b1;
        end else begin
            r.rem = qrs_pkg::DEN_W'(remx);
        end
        return r;
    endfunction

    always_comb begin
        n_q    = i_d;
        n_q.lp = step(i_d.lp, i_d.den);
        n_q.lm = step(i_d.lm, i_d.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire
